// ===== hdl/lfr_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU frame replacer package
// Shared command codes, field widths and channel payload types.
// ----------------------------------------------------------------------------
package lfr_pkg;

   // Field widths of the channel payloads.
   localparam int FRAME_ID_W  = 6;
   localparam int CMD_W       = 2;
   localparam int COUNT_W     = 7;

   // Frame ids are six bits wide, so no more than this many can be tracked.
   localparam int MAX_TRACKED = 64;

   // Width that holds any legal frame count for the range check.
   localparam int NUM_W       = 11;

   // Command codes. The remaining code is ignored by the block.
   localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PIN    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_UNPIN  = 2'd2;

   // One command as it arrives on the request channel.
   typedef struct packed {
      logic [CMD_W-1:0]      cmd;
      logic [FRAME_ID_W-1:0] frame_num;
   } req_type;

   // One result as it leaves on the response channel.
   typedef struct packed {
      logic                  victim_found;
      logic [FRAME_ID_W-1:0] victim_frame;
      logic [COUNT_W-1:0]    tracked_count;
   } rsp_type;

endpackage

// ===== hdl/lfr_in_reg.sv =====
// ----------------------------------------------------------------------------
// LRU frame replacer input register
// Holds one accepted request until the recency stack consumes it.
// ----------------------------------------------------------------------------
module lfr_in_reg
   import lfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   input  logic    advance,
   output logic    hold_valid,
   output req_type hold_payload
);

   logic    valid_ff;
   logic    valid_in;
   req_type payload_ff;

   // A new transfer is taken when the register is empty or drains this cycle.
   assign req_ready = ~valid_ff | advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // The payload needs no reset; it is qualified by the valid bit.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         payload_ff <= req_payload;
      end
   end

   assign hold_valid   = valid_ff;
   assign hold_payload = payload_ff;

endmodule

// ===== hdl/lfr_stack.sv =====
// ----------------------------------------------------------------------------
// LRU frame replacer recency stack
// A row of slots ordered from most to least recently used, with a compare
// on every slot and a one-step shift that executes one command per cycle with step set.
// ----------------------------------------------------------------------------
module lfr_stack
   import lfr_pkg::*;
#(
   parameter int NUM_FRAMES = 64
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   output rsp_type rsp
);

   localparam int DEPTH = (NUM_FRAMES < MAX_TRACKED) ? NUM_FRAMES : MAX_TRACKED;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [FRAME_ID_W-1:0] ids_ff [DEPTH];
   logic [FRAME_ID_W-1:0] ids_in [DEPTH];
   logic [DEPTH-1:0]      valid_ff;
   logic [DEPTH-1:0]      valid_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;

   // Slot views extended by one empty slot past the end of the row.
   logic [FRAME_ID_W-1:0] ids_ext [DEPTH+1];
   logic [DEPTH:0]        valid_ext;

   logic                  in_range;
   logic [DEPTH-1:0]      match;
   logic [DEPTH-1:0]      behind;
   logic                  found;
   logic [DEPTH-1:0]      last;
   logic [FRAME_ID_W-1:0] last_id;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ids_ext[i] = ids_ff[i];
      end
      ids_ext[DEPTH] = '0;
      valid_ext      = {1'b0, valid_ff};
   end

   // Frame ids at or above the frame count are ignored by pin and unpin.
   assign in_range = {{(NUM_W-FRAME_ID_W){1'b0}}, req.frame_num} < NUM_W'(NUM_FRAMES);

   // Compare the frame id against every tracked slot.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match[i] = valid_ff[i] && (ids_ff[i] == req.frame_num) && in_range;
      end
   end

   // Mark the slots that lie behind the matching slot.
   always_comb begin
      logic run;
      run = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         behind[i] = run;
         run       = run | match[i];
      end
      found = run;
   end

   // The least recently used frame sits in the last valid slot.
   always_comb begin
      last_id = '0;
      for (int i = 0; i < DEPTH; i++) begin
         last[i] = valid_ext[i] & ~valid_ext[i+1];
         last_id = last_id | (ids_ff[i] & {FRAME_ID_W{last[i]}});
      end
   end

   // Next state of the stack and the result of the command.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ids_in[i] = ids_ff[i];
      end
      valid_in          = valid_ff;
      count_in          = count_ff;
      rsp.victim_found  = 1'b0;
      rsp.victim_frame  = '0;
      if (step) begin
         unique case (req.cmd)
            CMD_VICTIM: begin
               if (valid_ff[0]) begin
                  rsp.victim_found = 1'b1;
                  rsp.victim_frame = last_id;
                  valid_in         = valid_ext[DEPTH:1];
                  count_in         = count_ff - 1'b1;
               end
            end
            CMD_PIN: begin
               // Close the gap left by the removed frame.
               if (found) begin
                  for (int i = 0; i < DEPTH; i++) begin
                     if (behind[i] || match[i]) begin
                        ids_in[i] = ids_ext[i+1];
                     end
                  end
                  valid_in = valid_ext[DEPTH:1];
                  count_in = count_ff - 1'b1;
               end
            end
            CMD_UNPIN: begin
               // Move the slots ahead of the frame back and put it in front.
               if (in_range && (found || !valid_ff[DEPTH-1])) begin
                  for (int i = 1; i < DEPTH; i++) begin
                     if (!behind[i]) begin
                        ids_in[i]   = ids_ff[i-1];
                        valid_in[i] = valid_ff[i-1];
                     end
                  end
                  ids_in[0]   = req.frame_num;
                  valid_in[0] = 1'b1;
                  if (!found) begin
                     count_in = count_ff + 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      rsp.tracked_count = COUNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   // Slot ids are only read where their valid bit is set.
   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         ids_ff[i] <= ids_in[i];
      end
   end

endmodule

// ===== hdl/lru_frame_replacer_core.sv =====
// ----------------------------------------------------------------------------
// LRU frame replacer core
// Recency order of evictable buffer frames with victim, pin and unpin
// commands, behind a request register and a response register.
// ----------------------------------------------------------------------------
// The block takes one command per clock cycle while the response side is not
// stalled and returns exactly one result for each, through the request and
// response registers. The rate is set by the recency stack: every slot compares
// its frame id in parallel and the whole row shifts by at most one place per
// command. The stack holds the smaller of NUM_FRAMES and 64 slots, since
// frame ids are six bits wide. After reset the order is empty and commands are
// accepted at once. Command code 3 is ignored and reports the current count.
module lru_frame_replacer_core
   import lfr_pkg::*;
#(
   parameter int NUM_FRAMES = 64
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic    hold_valid;
   req_type hold_payload;
   logic    advance;
   rsp_type stack_rsp;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_payload_ff;

   // A held command executes when the response register is free or draining.
   assign advance = hold_valid & (~rsp_valid_ff | rsp_ready);

   lfr_in_reg u_in_reg (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .advance      (advance),
      .hold_valid   (hold_valid),
      .hold_payload (hold_payload)
   );

   lfr_stack #(
      .NUM_FRAMES (NUM_FRAMES)
   ) u_stack (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (hold_payload),
      .rsp   (stack_rsp)
   );

   // Response register: loaded on every executed command.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_ff <= stack_rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// LRU frame replacer core testbench
// Drives victim, pin and unpin commands through the request channel, models
// the recency order alongside the block and checks every response field.
// Stimulus is a short directed sequence followed by random phases of fills,
// mixed traffic, drains, pin sweeps and noise, with bursty request traffic,
// a patterned response stall and one long response hold-off.
// ----------------------------------------------------------------------------
module tb;
   import lfr_pkg::*;

   // The one command code that the block ignores.
   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

   // Capacity of the recency order for the default frame count.
   localparam int ORDER_DEPTH = MAX_TRACKED;

   // Run limit in time units, far above the slowest correct run.
   localparam int RUN_LIMIT = 2400000;

   // Request count that arms the long response hold-off, and its length.
   localparam int HOLD_AFTER  = 600;
   localparam int HOLD_CYCLES = 400;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   lru_frame_replacer_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // Commands waiting to be driven, and responses predicted but not yet seen.
   req_type cmd_backlog[$];
   rsp_type replies_due[$];

   // Shadow copy of the recency order: slot 0 is the most recently used.
   logic [FRAME_ID_W-1:0] lru_ids[ORDER_DEPTH];
   int                    lru_count = 0;

   // Bookkeeping.
   int stim_count    = 0;
   int taken_count   = 0;
   int error_count   = 0;
   int victim_cmds   = 0;
   int pin_cmds      = 0;
   int unpin_cmds    = 0;
   int ignored_cmds  = 0;
   int evictions     = 0;
   int empty_victims = 0;
   int full_hits     = 0;
   rsp_type got_rsp;
   rsp_type want_rsp;

   // Clock.
   initial begin
      forever #6 clock = ~clock;
   end

   // Run limit.
   initial begin
      #(RUN_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // Applies one command to the shadow order and returns the response it gives.
   function automatic rsp_type apply_command(input req_type c);
      rsp_type r;
      int      pos;
      int      i;
      r   = '0;
      pos = -1;
      for (i = 0; i < lru_count; i++) begin
         if (pos < 0 && lru_ids[i] == c.frame_num) begin
            pos = i;
         end
      end
      case (c.cmd)
         CMD_VICTIM: begin
            if (lru_count > 0) begin
               r.victim_found = 1'b1;
               r.victim_frame = lru_ids[lru_count-1];
               lru_count--;
            end
         end
         CMD_PIN: begin
            if (pos >= 0) begin
               for (i = pos; i < lru_count - 1; i++) begin
                  lru_ids[i] = lru_ids[i+1];
               end
               lru_count--;
            end
         end
         CMD_UNPIN: begin
            // A tracked frame moves to the front; a new one is added there.
            if (pos < 0 && lru_count < ORDER_DEPTH) begin
               pos = lru_count;
               lru_count++;
            end
            if (pos >= 0) begin
               for (i = pos; i > 0; i--) begin
                  lru_ids[i] = lru_ids[i-1];
               end
               lru_ids[0] = c.frame_num;
            end
         end
         default: ;
      endcase
      r.tracked_count = lru_count[COUNT_W-1:0];
      return r;
   endfunction

   // Queues one command for the driver; ignored codes do not count as stimulus.
   task automatic add_cmd(input logic [CMD_W-1:0] c, input logic [FRAME_ID_W-1:0] f);
      cmd_backlog.push_back(req_type'{cmd: c, frame_num: f});
      if (c != CMD_RESERVED) begin
         stim_count++;
      end
   endtask

   // Holds the sender until every queued command has its response back.
   task automatic wait_drained();
      while (cmd_backlog.size() != 0 || req_valid || replies_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Request driver: bursts of random length with random gaps between them.
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_payload <= '0;
         burst_left  <= 0;
         gap_left    <= 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (cmd_backlog.size() > 0) begin
            req_payload <= cmd_backlog.pop_front();
            req_valid   <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response stall pattern, with one long hold-off while requests keep coming.
   int  stall_mode   = 0;
   int  pattern_left = 0;
   int  hold_left    = 0;
   logic hold_done   = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready    <= 1'b0;
         hold_left    <= 0;
         pattern_left <= 0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && req_valid && taken_count >= HOLD_AFTER) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            stall_mode   <= $urandom_range(0, 2);
            pattern_left <= $urandom_range(8, 80);
         end else begin
            pattern_left <= pattern_left - 1;
         end
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Monitor: checks each response transfer, then predicts each request transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got_rsp = rsp_payload;
            if (replies_due.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("Unexpected response: found=%0d frame=%0d count=%0d",
                           got_rsp.victim_found, got_rsp.victim_frame,
                           got_rsp.tracked_count);
               end
            end else begin
               want_rsp = replies_due.pop_front();
               if (got_rsp.victim_found !== want_rsp.victim_found ||
                   got_rsp.victim_frame !== want_rsp.victim_frame ||
                   got_rsp.tracked_count !== want_rsp.tracked_count) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("Mismatch: expected found=%0d frame=%0d count=%0d, %s",
                              want_rsp.victim_found, want_rsp.victim_frame,
                              want_rsp.tracked_count, "see actual below");
                     $display("          actual   found=%0d frame=%0d count=%0d",
                              got_rsp.victim_found, got_rsp.victim_frame,
                              got_rsp.tracked_count);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            want_rsp = apply_command(req_payload);
            replies_due.push_back(want_rsp);
            taken_count <= taken_count + 1;
            case (req_payload.cmd)
               CMD_VICTIM: begin
                  victim_cmds++;
                  if (want_rsp.victim_found) begin
                     evictions++;
                  end else begin
                     empty_victims++;
                  end
               end
               CMD_PIN:    pin_cmds++;
               CMD_UNPIN:  unpin_cmds++;
               default:    ignored_cmds++;
            endcase
            if (want_rsp.tracked_count == ORDER_DEPTH) begin
               full_hits++;
            end
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int kind;
      int n;
      int i;
      int j;
      int tmp;
      int hi;
      int w_unpin;
      int w_pin;
      int w_victim;
      int r;
      int perm[ORDER_DEPTH];
      logic first_fill;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty order, ignored code, add, move to front, removals.
      add_cmd(CMD_VICTIM, 6'd0);
      add_cmd(CMD_RESERVED, 6'd0);
      add_cmd(CMD_PIN, 6'd0);
      add_cmd(CMD_UNPIN, 6'd0);
      add_cmd(CMD_UNPIN, 6'd63);
      add_cmd(CMD_UNPIN, 6'd5);
      add_cmd(CMD_UNPIN, 6'd0);
      add_cmd(CMD_UNPIN, 6'd42);
      add_cmd(CMD_PIN, 6'd63);
      add_cmd(CMD_PIN, 6'd63);
      add_cmd(CMD_RESERVED, 6'd63);
      add_cmd(CMD_UNPIN, 6'd5);
      add_cmd(CMD_VICTIM, 6'd63);
      add_cmd(CMD_VICTIM, 6'd0);
      add_cmd(CMD_VICTIM, 6'd21);
      add_cmd(CMD_VICTIM, 6'd0);
      add_cmd(CMD_PIN, 6'd7);
      add_cmd(CMD_UNPIN, 6'd63);
      add_cmd(CMD_PIN, 6'd63);
      wait_drained();

      // Random phases; the first one always fills the order completely.
      first_fill = 1'b1;
      while (stim_count < 1400) begin
         kind = first_fill ? 0 : $urandom_range(0, 9);
         first_fill = 1'b0;
         if (kind <= 1) begin
            // Unpin every frame in a shuffled order, then touch and pin a few.
            for (i = 0; i < ORDER_DEPTH; i++) begin
               perm[i] = i;
            end
            for (i = ORDER_DEPTH - 1; i > 0; i--) begin
               j       = $urandom_range(0, i);
               tmp     = perm[i];
               perm[i] = perm[j];
               perm[j] = tmp;
            end
            for (i = 0; i < ORDER_DEPTH; i++) begin
               add_cmd(CMD_UNPIN, FRAME_ID_W'(perm[i]));
            end
            n = $urandom_range(20, 60);
            for (i = 0; i < n; i++) begin
               add_cmd(($urandom_range(0, 4) == 0) ? CMD_PIN : CMD_UNPIN,
                       FRAME_ID_W'($urandom_range(0, 63)));
            end
         end else if (kind <= 5) begin
            // Mixed traffic with a random command mix over a narrow or full id pool.
            n        = $urandom_range(30, 120);
            hi       = ($urandom_range(0, 1) == 0) ? $urandom_range(3, 15) : 63;
            w_unpin  = $urandom_range(1, 6);
            w_pin    = $urandom_range(0, 3);
            w_victim = $urandom_range(0, 3);
            for (i = 0; i < n; i++) begin
               r = $urandom_range(0, w_unpin + w_pin + w_victim - 1);
               if ($urandom_range(0, 19) == 0) begin
                  add_cmd(CMD_RESERVED, FRAME_ID_W'($urandom_range(0, 63)));
               end else if (r < w_unpin) begin
                  add_cmd(CMD_UNPIN, FRAME_ID_W'($urandom_range(0, hi)));
               end else if (r < w_unpin + w_pin) begin
                  add_cmd(CMD_PIN, FRAME_ID_W'($urandom_range(0, hi)));
               end else begin
                  add_cmd(CMD_VICTIM, FRAME_ID_W'($urandom_range(0, 63)));
               end
            end
         end else if (kind <= 7) begin
            // Drain by evicting, often past the point where the order is empty.
            n = $urandom_range(20, 70);
            for (i = 0; i < n; i++) begin
               add_cmd(CMD_VICTIM, FRAME_ID_W'($urandom_range(0, 63)));
            end
         end else if (kind == 8) begin
            // Noise: any code with any id.
            n = $urandom_range(20, 60);
            for (i = 0; i < n; i++) begin
               add_cmd(CMD_W'($urandom_range(0, 3)), FRAME_ID_W'($urandom_range(0, 63)));
            end
         end else begin
            // Pin sweep over every id, tracked or not.
            j = $urandom_range(0, 63);
            for (i = 0; i < ORDER_DEPTH; i++) begin
               add_cmd(CMD_PIN, FRAME_ID_W'((i + j) % ORDER_DEPTH));
            end
         end
         if ($urandom_range(0, 4) == 0) begin
            wait_drained();
         end
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (replies_due.size() != 0) begin
         error_count++;
      end

      $display("Ran %0d commands: %0d victim, %0d pin, %0d unpin, %0d ignored code.",
               taken_count, victim_cmds, pin_cmds, unpin_cmds, ignored_cmds);
      $display("Evicted %0d frames, %0d victims on an empty order, full order %0d times.",
               evictions, empty_victims, full_hits);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/lfr_pkg.sv
hdl/lfr_in_reg.sv
hdl/lfr_stack.sv
hdl/lru_frame_replacer_core.sv
tb/tb.sv
